@@ rtl/ssle_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ssle_pkg
// shared types and constants of the sorted slot list engine: command and
// status codes, controller states and the controller to datapath bundles
// ----------------------------------------------------------------------------
package ssle_pkg;

  localparam logic [7:0] EMPTY_VAL = 8'hff;
  localparam logic [5:0] END_MARK  = 6'd63;
  localparam logic [7:0] LIMIT_RST = 8'd100;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LIST   = 2'd2
  } ssle_op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SLOT  = 3'd1,
    ST_OCCUPIED  = 3'd2,
    ST_BAD_VALUE = 3'd3,
    ST_DUPLICATE = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_EMPTY     = 3'd6
  } ssle_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_WALK_RD,
    S_WALK_CHK,
    S_INS_LINK,
    S_INS_PREV,
    S_LIST_RD,
    S_LIST_CHK,
    S_RESP
  } ssle_state_t;

  typedef struct packed {
    logic         load;
    logic         scan_clr;
    logic         scan_inc;
    logic         rd_scan;
    logic         rd_cur;
    logic         set_found;
    logic         walk_init;
    logic         walk_step;
    logic         wr_value;
    logic         wr_link_slot;
    logic         wr_link_prev;
    logic         unlink;
    logic         clr_found;
    logic         emit;
    ssle_status_t emit_status;
    logic         emit_item;
    logic         emit_last;
  } ssle_cmd_t;

  typedef struct packed {
    ssle_op_t op;
    logic     slot_bad;
    logic     slot_occ;
    logic     value_bad;
    logic     head_end;
    logic     scan_match;
    logic     scan_last;
    logic     walk_end;
    logic     val_gt;
    logic     cur_is_found;
    logic     item_last;
    logic     out_free;
  } ssle_sts_t;

endpackage
`default_nettype wire

@@ rtl/ssle_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ssle_dp
// datapath: request registers, value and link memories with valid bits,
// head pointer, walk and scan counters, and the result register
// ----------------------------------------------------------------------------
module ssle_dp #(
  parameter int SLOTS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [15:0]       in_tdata,   // slot [5:0], value [13:6], zero [15:14]
  input  logic [1:0]        in_tuser,   // cmd [1:0]
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  input  ssle_pkg::ssle_cmd_t cmd,
  output ssle_pkg::ssle_sts_t sts,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,  // item_value [7:0], item_slot [13:8], zero [15:14]
  output logic [2:0]        out_tuser,  // status [2:0]
  output logic              out_tlast
);
  import ssle_pkg::*;

  localparam int         AW      = $clog2(SLOTS);
  localparam int         CW      = $clog2(SLOTS + 1);
  localparam logic [5:0] SLOTS_W = 6'(SLOTS);

  ssle_op_t          op_r;
  logic [5:0]        slot_r;
  logic [7:0]        value_r;
  logic [7:0]        limit_r;
  logic [SLOTS-1:0]  valid_r;
  logic [5:0]        head_r;
  logic [5:0]        cur_r;
  logic [5:0]        prev_r;
  logic [CW-1:0]     cnt_r;
  logic [AW-1:0]     idx_r;
  logic [AW-1:0]     found_r;

  logic [7:0]        val_mem [SLOTS];
  logic [5:0]        lnk_mem [SLOTS];
  logic [7:0]        rd_val_r;
  logic [5:0]        rd_lnk_r;
  logic              rd_vld_r;

  logic              out_valid_r;
  ssle_status_t      out_status_r;
  logic [7:0]        out_value_r;
  logic [5:0]        out_slot_r;
  logic              out_last_r;

  logic [AW-1:0]     slot_idx;
  logic [AW-1:0]     rd_addr;
  logic              rd_en;
  logic [7:0]        rd_val_eff;
  logic [5:0]        rd_lnk_eff;
  logic [5:0]        cur_lim;
  logic              prev_in;
  logic              lw_en;
  logic [AW-1:0]     lw_addr;
  logic [5:0]        lw_data;
  logic              hw_en;
  logic [5:0]        hw_data;
  logic [CW:0]       cnt_inc;

  assign slot_idx   = slot_r[AW-1:0];
  assign rd_en      = cmd.rd_scan | cmd.rd_cur;
  assign rd_addr    = cmd.rd_scan ? idx_r : cur_r[AW-1:0];
  assign rd_val_eff = rd_vld_r ? rd_val_r : EMPTY_VAL;
  assign rd_lnk_eff = rd_vld_r ? rd_lnk_r : END_MARK;
  assign cur_lim    = (cur_r < SLOTS_W) ? cur_r : END_MARK;
  assign prev_in    = prev_r < SLOTS_W;
  assign cnt_inc    = {1'b0, cnt_r} + (CW+1)'(1);

  // status towards the controller
  always_comb begin
    sts.op           = op_r;
    sts.slot_bad     = slot_r >= SLOTS_W;
    sts.slot_occ     = valid_r[slot_idx];
    sts.value_bad    = (value_r == EMPTY_VAL) || (value_r > limit_r);
    sts.head_end     = head_r >= SLOTS_W;
    sts.scan_match   = rd_vld_r && (rd_val_r == value_r);
    sts.scan_last    = idx_r == AW'(SLOTS - 1);
    sts.walk_end     = (cnt_r == CW'(SLOTS)) || (cur_r >= SLOTS_W);
    sts.val_gt       = rd_val_eff > value_r;
    sts.cur_is_found = cur_r == 6'(found_r);
    sts.item_last    = (rd_lnk_eff >= SLOTS_W) || (cnt_inc >= (CW+1)'(SLOTS));
    sts.out_free     = !out_valid_r || out_tready;
  end

  // request and configuration registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= ssle_op_t'(in_tuser);
      slot_r  <= in_tdata[5:0];
      value_r <= in_tdata[13:6];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // scan and walk pointers
  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      idx_r <= '0;
    end else if (cmd.scan_inc) begin
      idx_r <= idx_r + AW'(1);
    end
    if (cmd.set_found) begin
      found_r <= idx_r;
    end
    if (cmd.walk_init) begin
      cur_r  <= head_r;
      prev_r <= END_MARK;
      cnt_r  <= '0;
    end else if (cmd.walk_step) begin
      prev_r <= cur_r;
      cur_r  <= rd_lnk_eff;
      cnt_r  <= cnt_inc[CW-1:0];
    end
  end

  // link and head write selection
  always_comb begin
    lw_en   = 1'b0;
    lw_addr = slot_idx;
    lw_data = cur_lim;
    hw_en   = 1'b0;
    hw_data = slot_r;
    priority if (cmd.wr_link_slot) begin
      lw_en = 1'b1;
    end else if (cmd.wr_link_prev) begin
      lw_en   = prev_in;
      hw_en   = !prev_in;
      lw_addr = prev_r[AW-1:0];
      lw_data = slot_r;
    end else if (cmd.unlink) begin
      lw_en   = prev_in;
      hw_en   = !prev_in;
      lw_addr = prev_r[AW-1:0];
      lw_data = rd_lnk_eff;
      hw_data = rd_lnk_eff;
    end else begin
      lw_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= END_MARK;
      valid_r <= '0;
    end else begin
      if (hw_en) begin
        head_r <= hw_data;
      end
      if (cmd.wr_value) begin
        valid_r[slot_idx] <= 1'b1;
      end
      if (cmd.clr_found) begin
        valid_r[found_r] <= 1'b0;
      end
    end
  end

  // slot memories
  always_ff @(posedge clk) begin
    if (cmd.wr_value) begin
      val_mem[slot_idx] <= value_r;
    end
    if (lw_en) begin
      lnk_mem[lw_addr] <= lw_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_val_r <= val_mem[rd_addr];
      rd_lnk_r <= lnk_mem[rd_addr];
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      out_value_r  <= cmd.emit_item ? rd_val_eff : 8'd0;
      out_slot_r   <= cmd.emit_item ? cur_r : 6'd0;
      out_last_r   <= cmd.emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_slot_r, out_value_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

@@ rtl/ssle_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ssle_ctrl
// controller: sequences the slot scan, the list walk, the link updates and
// the result hand-off for each request
// ----------------------------------------------------------------------------
module ssle_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  ssle_pkg::ssle_sts_t sts,
  output ssle_pkg::ssle_cmd_t cmd
);
  import ssle_pkg::*;

  ssle_state_t  state_r;
  ssle_state_t  state_nxt;
  ssle_status_t status_r;
  ssle_status_t status_nxt;
  logic         is_ins;

  assign is_ins = sts.op == OP_INSERT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cmd        = '0;
    in_tready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.op)
          OP_INSERT: begin
            priority if (sts.slot_bad) begin
              status_nxt = ST_BAD_SLOT;
              state_nxt  = S_RESP;
            end else if (sts.slot_occ) begin
              status_nxt = ST_OCCUPIED;
              state_nxt  = S_RESP;
            end else if (sts.value_bad) begin
              status_nxt = ST_BAD_VALUE;
              state_nxt  = S_RESP;
            end else begin
              cmd.scan_clr = 1'b1;
              state_nxt    = S_SCAN_RD;
            end
          end
          OP_DELETE: begin
            if (sts.value_bad) begin
              status_nxt = ST_BAD_VALUE;
              state_nxt  = S_RESP;
            end else begin
              cmd.scan_clr = 1'b1;
              state_nxt    = S_SCAN_RD;
            end
          end
          OP_LIST: begin
            if (sts.head_end) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_RESP;
            end else begin
              cmd.walk_init = 1'b1;
              state_nxt     = S_LIST_RD;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_SCAN_RD: begin
        cmd.rd_scan = 1'b1;
        state_nxt   = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        priority if (sts.scan_match) begin
          if (is_ins) begin
            status_nxt = ST_DUPLICATE;
            state_nxt  = S_RESP;
          end else begin
            cmd.set_found = 1'b1;
            cmd.walk_init = 1'b1;
            state_nxt     = S_WALK_RD;
          end
        end else if (sts.scan_last) begin
          if (is_ins) begin
            cmd.wr_value  = 1'b1;
            cmd.walk_init = 1'b1;
            state_nxt     = S_WALK_RD;
          end else begin
            status_nxt = ST_NOT_FOUND;
            state_nxt  = S_RESP;
          end
        end else begin
          cmd.scan_inc = 1'b1;
          state_nxt    = S_SCAN_RD;
        end
      end
      S_WALK_RD: begin
        if (sts.walk_end) begin
          if (is_ins) begin
            state_nxt = S_INS_LINK;
          end else begin
            cmd.clr_found = 1'b1;
            status_nxt    = ST_OK;
            state_nxt     = S_RESP;
          end
        end else begin
          cmd.rd_cur = 1'b1;
          state_nxt  = S_WALK_CHK;
        end
      end
      S_WALK_CHK: begin
        if (is_ins) begin
          if (sts.val_gt) begin
            state_nxt = S_INS_LINK;
          end else begin
            cmd.walk_step = 1'b1;
            state_nxt     = S_WALK_RD;
          end
        end else begin
          if (sts.cur_is_found) begin
            cmd.unlink    = 1'b1;
            cmd.clr_found = 1'b1;
            status_nxt    = ST_OK;
            state_nxt     = S_RESP;
          end else begin
            cmd.walk_step = 1'b1;
            state_nxt     = S_WALK_RD;
          end
        end
      end
      S_INS_LINK: begin
        cmd.wr_link_slot = 1'b1;
        state_nxt        = S_INS_PREV;
      end
      S_INS_PREV: begin
        cmd.wr_link_prev = 1'b1;
        status_nxt       = ST_OK;
        state_nxt        = S_RESP;
      end
      S_LIST_RD: begin
        cmd.rd_cur = 1'b1;
        state_nxt  = S_LIST_CHK;
      end
      S_LIST_CHK: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_OK;
          cmd.emit_item   = 1'b1;
          cmd.emit_last   = sts.item_last;
          if (sts.item_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.walk_step = 1'b1;
            state_nxt     = S_LIST_RD;
          end
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = status_r;
          cmd.emit_last   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/sorted_slot_list_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_slot_list_engine
// table of value slots threaded as a linked list in ascending value order
//
// in channel: one request per handshake, cmd in in_tuser (insert, delete by
// value, list), slot and value in in_tdata. out channel: status in out_tuser,
// listed value and slot in out_tdata, out_tlast on the final result of a
// request. cfg_we writes the value limit (reset 100).
// one request is worked on at a time; in_tready is high only when idle.
// insert scans all SLOTS slots unless it meets a duplicate, delete up to the
// first match, each through the registered memory read; then both walk the
// list. requests rejected by the slot and value checks answer without a
// scan; list gives its results one at a time while it walks. a result waits
// in the output register while out_tready is low and the engine stalls
// until it is taken; a new request is taken as soon as the last result sits
// in that register.
// reset empties the list at once (valid bits) and sets the limit to 100.
// ----------------------------------------------------------------------------
module sorted_slot_list_engine #(
  parameter int SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // slot [5:0], value [13:6], zero [15:14]
  input  logic [1:0]  in_tuser,    // cmd [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // item_value [7:0], item_slot [13:8], zero [15:14]
  output logic [2:0]  out_tuser,   // status [2:0]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);
  import ssle_pkg::*;

  ssle_cmd_t cmd;
  ssle_sts_t sts;

  ssle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ssle_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire
